### sv/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types, constants and helpers of the d-pad diagonal sweep cleaner.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int DSC_QUEUE_DEPTH = 16;
    localparam logic [15:0] DSC_DELAY_RESET = 16'd30;

    typedef logic [3:0] t_dir;

    localparam t_dir DIR_NONE  = 4'h0;
    localparam t_dir DIR_UP    = 4'h1;
    localparam t_dir DIR_DOWN  = 4'h2;
    localparam t_dir DIR_LEFT  = 4'h4;
    localparam t_dir DIR_RIGHT = 4'h8;

    typedef struct packed {
        t_dir        dpad_in;
        logic        toggle_level;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_dir dpad_out;
        logic led_on;
        logic active;
        logic overflow;
    } t_res;

    // one queue row: a single direction, or a cardinal plus the new sample
    typedef struct packed {
        logic pair;
        t_dir first;
        t_dir second;
    } t_row;

    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
        t_row row;
    } t_q_cmd;

    typedef struct packed {
        logic nonempty;  // before clear and pop
        logic empty_a;   // after clear and pop
        logic free1;
        logic free2;
        t_dir front;
    } t_q_stat;

    function automatic logic f_is_diag(input t_dir d);
        return (d == (DIR_UP | DIR_LEFT)) || (d == (DIR_UP | DIR_RIGHT)) ||
               (d == (DIR_DOWN | DIR_LEFT)) || (d == (DIR_DOWN | DIR_RIGHT));
    endfunction

    function automatic t_dir f_shared(input t_dir a, input t_dir b);
        t_dir common;
        common = a & b;
        if (!f_is_diag(a) || !f_is_diag(b) || (a == b)) begin
            return DIR_NONE;
        end
        if ((common == DIR_UP) || (common == DIR_DOWN) ||
            (common == DIR_LEFT) || (common == DIR_RIGHT)) begin
            return common;
        end
        return DIR_NONE;
    endfunction

endpackage

### sv/dsc_ifs.sv
// ----------------------------------------------------------------------------
// dsc channel interfaces
// Sample input, result output and delay register write channels.
// ----------------------------------------------------------------------------
interface dsc_in_if;
    import dsc_pkg::*;
    logic        valid;
    logic        ready;
    t_dir        dpad_in;
    logic        toggle_level;
    logic [31:0] now_ms;
    modport source (output valid, output dpad_in, output toggle_level, output now_ms,
                    input ready);
    modport sink (input valid, input dpad_in, input toggle_level, input now_ms,
                  output ready);
endinterface

interface dsc_out_if;
    import dsc_pkg::*;
    logic valid;
    logic ready;
    t_dir dpad_out;
    logic led_on;
    logic active;
    logic overflow;
    modport source (output valid, output dpad_out, output led_on, output active,
                    output overflow, input ready);
    modport sink (input valid, input dpad_out, input led_on, input active,
                  input overflow, output ready);
endinterface

interface dsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] delay_ms;
    modport source (output valid, output delay_ms, input ready);
    modport sink (input valid, input delay_ms, output ready);
endinterface

### sv/dpad_diagonal_sweep_cleaner.sv
// ----------------------------------------------------------------------------
// dpad_diagonal_sweep_cleaner
// Inserts the shared cardinal between adjacent diagonal jumps and paces
// queued directions by a programmable hold time.
// ----------------------------------------------------------------------------
//  channel  | dir | carries
//  i_in     | in  | dpad_in, toggle_level, now_ms
//  o_out    | out | dpad_out, led_on, active, overflow
//  i_cfg    | in  | delay_ms (always ready)
//
//  A request passes the input register, then the result register; one request per cycle unless stalled.
//  Throughput is set by the step between input and result register.
//  Synchronous active-low reset: mode off, queue empty, delay 30 ms.
//  A stalled result holds the input stage; a new request is taken as it drains.
// ----------------------------------------------------------------------------
module dpad_diagonal_sweep_cleaner #(
    parameter int QUEUE_DEPTH = dsc_pkg::DSC_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dsc_in_if.sink        i_in,
    dsc_out_if.source     o_out,
    dsc_cfg_if.sink       i_cfg
);
    import dsc_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_res        r_out;
    logic [15:0] r_delay;

    logic        advance;
    t_q_cmd      qcmd;
    t_q_stat     qstat;
    t_res        res;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= '{dpad_in: i_in.dpad_in, toggle_level: i_in.toggle_level,
                      now_ms: i_in.now_ms};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DSC_DELAY_RESET;
        end else if (i_cfg.valid) begin
            r_delay <= i_cfg.delay_ms;
        end
    end

    dsc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_delay (r_delay),
        .i_qstat (qstat),
        .o_qcmd  (qcmd),
        .o_res   (res)
    );

    dsc_queue #(
        .QueueDepth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cmd   (qcmd),
        .o_stat  (qstat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.dpad_out = r_out.dpad_out;
    assign o_out.led_on   = r_out.led_on;
    assign o_out.active   = r_out.active;
    assign o_out.overflow = r_out.overflow;

endmodule

### sv/dsc_queue.sv
// ----------------------------------------------------------------------------
// dsc_queue
// Direction queue: row memory, cached head row and prefetched next row.
// ----------------------------------------------------------------------------
module dsc_queue #(
    parameter int QueueDepth = dsc_pkg::DSC_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  dsc_pkg::t_q_cmd  i_cmd,
    output dsc_pkg::t_q_stat o_stat
);
    import dsc_pkg::*;

    localparam int AW = $clog2(QueueDepth);
    localparam int CW = $clog2(QueueDepth + 1);
    localparam logic [AW-1:0] LAST = AW'(QueueDepth - 1);

    t_row mem [QueueDepth];

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rows, n_rows;
    logic [AW-1:0] r_hrow, n_hrow;
    logic          r_hsub, n_hsub;
    t_row          r_hdata, n_hdata;
    t_row          r_pf;

    logic [CW-1:0] c_count, c_rows, a_count, a_rows;
    logic [AW-1:0] c_hrow, a_hrow, wa, rd_addr;
    logic          c_hsub, a_hsub, we;
    t_row          a_hdata;
    logic [CW:0]   tail_sum;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        c_count = i_cmd.clear ? '0 : r_count;
        c_rows  = i_cmd.clear ? '0 : r_rows;
        c_hrow  = i_cmd.clear ? '0 : r_hrow;
        c_hsub  = i_cmd.clear ? 1'b0 : r_hsub;

        a_count = c_count;
        a_rows  = c_rows;
        a_hrow  = c_hrow;
        a_hsub  = c_hsub;
        a_hdata = r_hdata;
        if (i_cmd.pop) begin
            a_count = c_count - CW'(1);
            if (r_hdata.pair && !c_hsub) begin
                a_hsub = 1'b1;
            end else begin
                a_hsub  = 1'b0;
                a_hrow  = f_inc(c_hrow);
                a_rows  = c_rows - CW'(1);
                a_hdata = r_pf;
            end
        end

        tail_sum = (CW+1)'(a_hrow) + (CW+1)'(a_rows);
        if (tail_sum >= (CW+1)'(QueueDepth)) begin
            tail_sum = tail_sum - (CW+1)'(QueueDepth);
        end
        wa = AW'(tail_sum);
        we = i_step && i_cmd.push;

        n_count = a_count;
        n_rows  = a_rows;
        n_hrow  = a_hrow;
        n_hsub  = a_hsub;
        n_hdata = a_hdata;
        if (i_cmd.push) begin
            n_count = a_count + (i_cmd.row.pair ? CW'(2) : CW'(1));
            n_rows  = a_rows + CW'(1);
            if (a_count == '0) begin
                n_hdata = i_cmd.row;
                n_hsub  = 1'b0;
            end
        end
        if (!i_step) begin
            n_count = r_count;
            n_rows  = r_rows;
            n_hrow  = r_hrow;
            n_hsub  = r_hsub;
            n_hdata = r_hdata;
        end
        rd_addr = f_inc(n_hrow);

        o_stat.nonempty = (r_count != '0);
        o_stat.empty_a  = (a_count == '0);
        o_stat.free1    = (a_count < CW'(QueueDepth));
        o_stat.free2    = (a_count < CW'(QueueDepth - 1));
        o_stat.front    = a_hsub ? a_hdata.second : a_hdata.first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rows  <= '0;
            r_hrow  <= '0;
            r_hsub  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rows  <= n_rows;
            r_hrow  <= n_hrow;
            r_hsub  <= n_hsub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdata <= n_hdata;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= i_cmd.row;
        end
    end

    // next row after head, bypassing a same-cycle write
    always_ff @(posedge i_clk) begin
        if (we && (wa == rd_addr)) begin
            r_pf <= i_cmd.row;
        end else begin
            r_pf <= mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QueueDepth))
        else $error("queue count above depth");
    a_rows_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= r_count)
        else $error("more rows than directions");
    a_empty_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> ((r_rows == '0) && !r_hsub))
        else $error("empty queue with rows left");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cmd.pop) |-> (r_count != '0) && !i_cmd.clear)
        else $error("pop of empty queue");
`endif
endmodule

### sv/dsc_step.sv
// ----------------------------------------------------------------------------
// dsc_step
// Mode toggle, diagonal jump detection, deadline and queue control.
// ----------------------------------------------------------------------------
module dsc_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  dsc_pkg::t_in_item i_item,
    input  logic [15:0]      i_delay,
    input  dsc_pkg::t_q_stat i_qstat,
    output dsc_pkg::t_q_cmd  o_qcmd,
    output dsc_pkg::t_res    o_res
);
    import dsc_pkg::*;

    logic        r_mode, n_mode;
    logic        r_released, n_released;
    t_dir        r_prev, n_prev;
    logic [31:0] r_deadline, n_deadline;
    logic        r_led, n_led;

    logic        flip;
    logic        changed;
    logic        dropped;
    t_dir        inj;
    t_dir        clean;
    logic [31:0] next_deadline;

    always_comb begin
        flip          = i_item.toggle_level && r_released;
        n_mode        = r_mode ^ flip;
        n_released    = !i_item.toggle_level;
        n_led         = flip ? n_mode : r_led;
        n_prev        = r_prev;
        n_deadline    = r_deadline;
        inj           = f_shared(r_prev, i_item.dpad_in);
        changed       = (r_prev != i_item.dpad_in);
        next_deadline = i_item.now_ms + 32'(i_delay);
        clean         = i_item.dpad_in;
        dropped       = 1'b0;

        o_qcmd.clear = flip;
        o_qcmd.pop   = n_mode && i_qstat.nonempty && !flip &&
                       (i_item.now_ms > r_deadline);
        o_qcmd.push  = 1'b0;
        o_qcmd.row   = '{pair: 1'b0, first: i_item.dpad_in, second: DIR_NONE};

        if (n_mode) begin
            if (o_qcmd.pop) begin
                if (!i_qstat.empty_a) begin
                    n_deadline = next_deadline;
                    n_led      = 1'b0;
                end else begin
                    n_led = 1'b1;
                end
            end
            if (!i_qstat.empty_a) begin
                clean = i_qstat.front;
                if (changed) begin
                    if (inj != DIR_NONE) begin
                        if (i_qstat.free2) begin
                            o_qcmd.push = 1'b1;
                            o_qcmd.row  = '{pair: 1'b1, first: inj,
                                            second: i_item.dpad_in};
                        end else if (i_qstat.free1) begin
                            o_qcmd.push = 1'b1;
                            o_qcmd.row  = '{pair: 1'b0, first: inj, second: DIR_NONE};
                            dropped     = 1'b1;
                        end else begin
                            dropped = 1'b1;
                        end
                    end else if (i_qstat.free1) begin
                        o_qcmd.push = 1'b1;
                    end else begin
                        dropped = 1'b1;
                    end
                end
            end else if (changed && (inj != DIR_NONE)) begin
                o_qcmd.push = 1'b1;
                o_qcmd.row  = '{pair: 1'b1, first: inj, second: i_item.dpad_in};
                n_deadline  = next_deadline;
                clean       = inj;
            end
            n_prev = i_item.dpad_in;
        end

        o_res.dpad_out = clean;
        o_res.led_on   = n_led;
        o_res.active   = n_mode;
        o_res.overflow = dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_released <= 1'b0;
            r_prev     <= DIR_NONE;
            r_deadline <= '0;
            r_led      <= 1'b0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_released <= n_released;
            r_prev     <= n_prev;
            r_deadline <= n_deadline;
            r_led      <= n_led;
        end
    end

`ifndef SYNTHESIS
    a_flip_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && flip) |=> !r_released)
        else $error("toggle not locked after flip");
    a_idle_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_mode |-> (!o_qcmd.push && !o_qcmd.pop && !o_res.overflow))
        else $error("queue activity while mode off");
`endif
endmodule
